FILE: sv/lane_multiply_xor_hash64_top_macros.svh
// Assertion macros shared by the hash block checker.
`ifndef LANE_MULTIPLY_XOR_HASH64_TOP_MACROS_SVH
`define LANE_MULTIPLY_XOR_HASH64_TOP_MACROS_SVH

// Next-cycle implication, masked during reset.
`define LMXH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define LMXH_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("check failed");

`endif

FILE: sv/lmxh_pkg.sv
// Shared constants, command type and arithmetic helpers of the hash block.
package lmxh_pkg;

  localparam int DEF_LANE_COUNT = 8;
  localparam logic [31:0] GOLD32 = 32'h9E3779B9;
  localparam logic [63:0] GOLD64 = 64'h9E3779B97F4A7C15;
  localparam logic [3:0]  WORD_BYTES = 4'd8;

  // Controller to datapath commands.
  typedef struct packed {
    logic start;    // load message seed, mark all halves fresh
    logic abs1;     // first absorb half: xor word, multiply parts
    logic use_in;   // absorb the input word (else a zero pad word)
    logic abs2;     // second absorb half: xorshift, multiply, write back
    logic acc_len;  // fold accumulator takes the length
    logic acc_xor;  // fold accumulator xors in the addressed half
    logic mul0;     // 64-bit constant multiply, low partial product
    logic mul1;     // cross product one
    logic mul2;     // cross product two and sum
    logic out_load; // final mix into the output register
  } lmxh_cmd_t;

  function automatic logic [63:0] mul_parts(input logic [63:0] x);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = x[31:0] * GOLD32;
    hi = x[63:32] * GOLD32;
    return {hi, lo};
  endfunction

  function automatic logic [63:0] xshift(input logic [63:0] x);
    return x ^ (x >> 16) ^ (x << 32);
  endfunction

  // Start value of half k: G*(2k+1) low, G*(2k+2) high.
  function automatic logic [63:0] golden_half(input logic [31:0] k);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = GOLD32 * ((k << 1) + 32'd1);
    hi = GOLD32 * ((k << 1) + 32'd2);
    return {hi, lo};
  endfunction

  // Byte count that counts: saturated on a last word, all eight otherwise.
  function automatic logic [3:0] sat_bytes(input logic [3:0] vb, input logic last);
    if (!last || vb > WORD_BYTES) begin
      return WORD_BYTES;
    end
    return vb;
  endfunction

endpackage

FILE: sv/lane_multiply_xor_hash64_top.sv
// Lane multiply-xor 64-bit hash: top level joining controller and datapath.
// A word that is not last is accepted and absorbed, then written back, before the next is taken.
// A last word at half i (of H = 2*LANE_COUNT) is absorbed, the halves above i get zero pad words,
//   plus one whole zero block when the message fills its block exactly, then a fold
//   (length, H xor steps, H+2 64-bit multiplies), then the load.
// The fold pace is set by the 32x32 partial-product multiplies, done in steps M0, M1 and M2.
// Reset (rst_n low, synchronous): seed 0, no message open, output empty.
module lane_multiply_xor_hash64_top
  import lmxh_pkg::*;
#(
  parameter int LANE_COUNT = DEF_LANE_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: seed
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // [63:0] data_word, [67:64] valid_bytes, [71:68] zero
  input  logic        in_tlast,  // last_word
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata  // [63:0] hash_value
);

  localparam int HALF_COUNT = 2 * LANE_COUNT;
  localparam int IDX_W = (HALF_COUNT > 1) ? $clog2(HALF_COUNT) : 1;
  localparam int LEN_W = $clog2(16 * LANE_COUNT + 1);

  logic [IDX_W-1:0] idx;
  logic [LEN_W-1:0] len;
  lmxh_cmd_t        cmd;

  // controller owns sequencing and both handshakes
  lmxh_ctrl #(
    .LANE_COUNT(LANE_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_last   (in_tlast),
    .in_vb     (in_tdata[67:64]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .idx       (idx),
    .len       (len),
    .cmd       (cmd)
  );

  // datapath holds halves, seed and the output register
  lmxh_datapath #(
    .LANE_COUNT(LANE_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_word     (in_tdata[63:0]),
    .in_vb       (in_tdata[67:64]),
    .in_last     (in_tlast),
    .idx         (idx),
    .len         (len),
    .cmd         (cmd),
    .hash_out    (out_tdata)
  );

endmodule

FILE: sv/lmxh_datapath.sv
// Hash datapath: accumulator halves, absorb pipeline, fold multiplier, output register.
module lmxh_datapath
  import lmxh_pkg::*;
#(
  parameter int LANE_COUNT = DEF_LANE_COUNT,
  localparam int HALF_COUNT = 2 * LANE_COUNT,
  localparam int IDX_W = (HALF_COUNT > 1) ? $clog2(HALF_COUNT) : 1,
  localparam int LEN_W = $clog2(16 * LANE_COUNT + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [63:0]      cfg_wr_data,
  input  logic [63:0]      in_word,
  input  logic [3:0]       in_vb,
  input  logic             in_last,
  input  logic [IDX_W-1:0] idx,
  input  logic [LEN_W-1:0] len,
  input  lmxh_cmd_t        cmd,
  output logic [63:0]      hash_out
);

  logic [63:0] seed_r;
  logic [63:0] seed_msg_r;
  logic [63:0] half_r [HALF_COUNT];
  logic [HALF_COUNT-1:0] fresh_r;
  logic [63:0] x1_r;
  logic [63:0] acc_r;
  logic [63:0] p_r;
  logic [31:0] q_r;
  logic [63:0] hash_r;

  logic [63:0] rd_half;
  logic [63:0] seed_use;
  logic [63:0] word_m;
  logic [3:0]  nb;
  logic [63:0] t;
  logic [31:0] q2;

  assign seed_use = cmd.start ? seed_r : seed_msg_r;
  assign rd_half  = (cmd.start || fresh_r[idx]) ?
                    (golden_half(32'(idx)) ^ seed_use) : half_r[idx];

  always_comb begin
    nb = sat_bytes(in_vb, in_last);
    for (int j = 0; j < 8; j++) begin
      word_m[8*j +: 8] = (4'(j) < nb) ? in_word[8*j +: 8] : 8'h00;
    end
  end

  assign t  = acc_r ^ (acc_r >> 32);
  assign q2 = t[63:32] * GOLD64[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= '0;
      fresh_r <= '1;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      if (cmd.start) begin
        fresh_r <= '1;
      end else if (cmd.abs2) begin
        fresh_r[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      seed_msg_r <= seed_r;
    end
    if (cmd.abs1) begin
      x1_r <= mul_parts(rd_half ^ (cmd.use_in ? word_m : 64'd0));
    end
    if (cmd.abs2) begin
      half_r[idx] <= mul_parts(xshift(x1_r));
    end
    if (cmd.acc_len) begin
      acc_r <= 64'(len);
    end else if (cmd.acc_xor) begin
      acc_r <= acc_r ^ rd_half;
    end else if (cmd.mul2) begin
      acc_r <= p_r + {q_r + q2, 32'd0};
    end
    if (cmd.mul0) begin
      p_r <= 64'(t[31:0]) * 64'(GOLD64[31:0]);
    end
    if (cmd.mul1) begin
      q_r <= t[31:0] * GOLD64[63:32];
    end
    if (cmd.out_load) begin
      hash_r <= acc_r ^ (acc_r >> 32);
    end
  end

  assign hash_out = hash_r;

endmodule

FILE: sv/lmxh_ctrl.sv
// Hash controller: word sequencing, block padding, fold steps and output handshake.
module lmxh_ctrl
  import lmxh_pkg::*;
#(
  parameter int LANE_COUNT = DEF_LANE_COUNT,
  localparam int HALF_COUNT = 2 * LANE_COUNT,
  localparam int IDX_W = (HALF_COUNT > 1) ? $clog2(HALF_COUNT) : 1,
  localparam int BLOCK_BYTES = 16 * LANE_COUNT,
  localparam int LEN_W = $clog2(BLOCK_BYTES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_last,
  input  logic [3:0]       in_vb,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] idx,
  output logic [LEN_W-1:0] len,
  output lmxh_cmd_t        cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_A2   = 4'd1;
  localparam logic [3:0] S_PA1  = 4'd2;
  localparam logic [3:0] S_PA2  = 4'd3;
  localparam logic [3:0] S_FLEN = 4'd4;
  localparam logic [3:0] S_FX   = 4'd5;
  localparam logic [3:0] S_M0   = 4'd6;
  localparam logic [3:0] S_M1   = 4'd7;
  localparam logic [3:0] S_M2   = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HALF_COUNT - 1);

  logic [3:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             last_r, last_nxt;
  logic [3:0]       vb_r, vb_nxt;
  logic             in_msg_r, in_msg_nxt;
  logic             fxd_r, fxd_nxt;
  logic             fin_r, fin_nxt;
  logic             oval_r, oval_nxt;
  logic [LEN_W-1:0] sum;
  logic             accept;

  assign accept = in_valid && (state_r == S_IDLE);
  assign sum    = LEN_W'({idx_r, 3'b000}) + LEN_W'(vb_r);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    last_nxt   = last_r;
    vb_nxt     = vb_r;
    in_msg_nxt = in_msg_r;
    fxd_nxt    = fxd_r;
    fin_nxt    = fin_r;
    oval_nxt   = oval_r && !out_ready;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.abs1   = 1'b1;
          cmd.use_in = 1'b1;
          cmd.start  = !in_msg_r;
          in_msg_nxt = 1'b1;
          last_nxt   = in_last;
          vb_nxt     = sat_bytes(in_vb, in_last);
          state_nxt  = S_A2;
        end
      end
      S_A2: begin
        cmd.abs2 = 1'b1;
        if (!last_r) begin
          idx_nxt   = (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
          state_nxt = S_IDLE;
        end else begin
          len_nxt = (sum == LEN_W'(BLOCK_BYTES)) ? '0 : sum;
          if (idx_r != IDX_LAST) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_PA1;
          end else if (vb_r == WORD_BYTES) begin
            // message ends on a block boundary: one whole zero block more
            idx_nxt   = '0;
            state_nxt = S_PA1;
          end else begin
            state_nxt = S_FLEN;
          end
        end
      end
      S_PA1: begin
        cmd.abs1  = 1'b1;
        state_nxt = S_PA2;
      end
      S_PA2: begin
        cmd.abs2 = 1'b1;
        if (idx_r != IDX_LAST) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_PA1;
        end else begin
          state_nxt = S_FLEN;
        end
      end
      S_FLEN: begin
        cmd.acc_len = 1'b1;
        idx_nxt     = '0;
        fxd_nxt     = 1'b0;
        fin_nxt     = 1'b0;
        state_nxt   = S_M0;
      end
      S_FX: begin
        cmd.acc_xor = 1'b1;
        if (idx_r == IDX_LAST) begin
          fxd_nxt = 1'b1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
        state_nxt = S_M0;
      end
      S_M0: begin
        cmd.mul0  = 1'b1;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.mul2 = 1'b1;
        if (!fxd_r) begin
          state_nxt = S_FX;
        end else if (!fin_r) begin
          fin_nxt   = 1'b1;
          state_nxt = S_M0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!oval_r || out_ready) begin
          cmd.out_load = 1'b1;
          oval_nxt     = 1'b1;
          in_msg_nxt   = 1'b0;
          idx_nxt      = '0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      in_msg_r <= 1'b0;
      oval_r   <= 1'b0;
      fxd_r    <= 1'b0;
      fin_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      in_msg_r <= in_msg_nxt;
      oval_r   <= oval_nxt;
      fxd_r    <= fxd_nxt;
      fin_r    <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    last_r <= last_nxt;
    vb_r   <= vb_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = oval_r;
  assign idx       = idx_r;
  assign len       = len_r;

endmodule

FILE: sv/lmxh_checker.sv
// Port-level checker for the hash block, bound to the top level.
`include "lane_multiply_xor_hash64_top_macros.svh"

module lmxh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // a stalled result holds
  `LMXH_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // every accepted item is followed by in_tready low
  `LMXH_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  // a last item never yields its hash in the very next cycle
  `LMXH_ASSERT_NEXT(a_no_instant_hash, in_tvalid && in_tready && in_tlast && !out_tvalid,
                    !out_tvalid)
  // reset empties the output
  `LMXH_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_tvalid)

endmodule

bind lane_multiply_xor_hash64_top lmxh_checker u_lmxh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: sim/lmxh_checker.sv
// Checker for the hash block: watches the channels, predicts hashes and compares them.
module lmxh_tb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  output int          fail_count,
  output int          pending
);
  localparam int HALVES = 16;
  localparam int BLOCK = 128;
  localparam logic [31:0] G32 = 32'h9E3779B9;
  localparam logic [63:0] G64 = 64'h9E3779B97F4A7C15;

  logic [63:0] seed_q;
  logic [63:0] acc [HALVES];
  int          blk_bytes;
  logic        msg_open;
  logic [63:0] hash_q [$];

  function automatic logic [63:0] gold_mul(input logic [63:0] x);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = x[31:0] * G32;
    hi = x[63:32] * G32;
    return {hi, lo};
  endfunction

  task automatic absorb(input int k, input logic [63:0] w);
    logic [63:0] x;
    x = gold_mul(acc[k] ^ w);
    x = x ^ (x >> 16) ^ (x << 32);
    acc[k] = gold_mul(x);
  endtask

  task automatic load_seeded();
    logic [31:0] lo;
    logic [31:0] hi;
    for (int k = 0; k < HALVES; k++) begin
      lo = G32 * (2 * k + 1);
      hi = G32 * (2 * k + 2);
      acc[k] = {hi, lo} ^ seed_q;
    end
  endtask

  task automatic hash_word(input logic [63:0] w, input logic [3:0] vb, input logic lst);
    int          pos;
    int          slot;
    int          nb;
    logic [63:0] h;
    if (!msg_open) begin
      load_seeded();
      blk_bytes = 0;
      msg_open  = 1'b1;
    end
    pos  = blk_bytes % BLOCK;
    slot = pos / 8;
    if (!lst) begin
      absorb(slot, w);
      blk_bytes = (pos + 8) % BLOCK;
    end else begin
      nb = (vb > 8) ? 8 : vb;
      if (nb < 8) w = w & ((64'd1 << (8 * nb)) - 64'd1);
      absorb(slot, w);
      for (int k = slot + 1; k < HALVES; k++) absorb(k, 64'd0);
      if (pos + nb == BLOCK)
        for (int k = 0; k < HALVES; k++) absorb(k, 64'd0);
      h = 64'((pos + nb) % BLOCK) * G64;
      for (int k = 0; k < HALVES; k++) begin
        h = h ^ acc[k];
        h = (h ^ (h >> 32)) * G64;
      end
      h = (h ^ (h >> 32)) * G64;
      hash_q.push_back(h ^ (h >> 32));
      blk_bytes = 0;
      msg_open  = 1'b0;
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    seed_q     = '0;
    blk_bytes  = 0;
    msg_open   = 1'b0;
    load_seeded();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      seed_q    = '0;
      blk_bytes = 0;
      msg_open  = 1'b0;
      load_seeded();
      hash_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (hash_q.size() == 0) report("unexpected hash", out_tdata, 64'd0);
        else begin
          if (out_tdata !== hash_q[0]) report("hash_value", out_tdata, hash_q[0]);
          void'(hash_q.pop_front());
        end
      end
      if (in_tvalid && in_tready) hash_word(in_tdata[63:0], in_tdata[67:64], in_tlast);
      if (cfg_wr_en) seed_q = cfg_wr_data;
    end
    pending = hash_q.size();
  end
endmodule

FILE: sim/tb_lane_multiply_xor_hash64_top.sv
// Testbench top: stimulus, stalls, seed phases and verdict for the hash block.
module tb_lane_multiply_xor_hash64_top;
  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [63:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          sent = 0;
  bit          gaps_on = 1'b1;   // off: both sides run flat out
  bit          hold_req = 1'b0;  // asks the receiver for one long stall

  localparam int CYC_LIMIT = 400000;
  localparam int DRAIN = 200;    // beyond worst last-word latency

  always #5 clk = ~clk;

  lane_multiply_xor_hash64_top dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata
  );

  lmxh_tb_checker chk (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata,
    .fail_count, .pending
  );

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random back-pressure per hash, one long hold-off on request so
  // the block backs up and drops in_tready while the sender keeps offering.
  initial begin
    int n;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        n = 400;
        hold_req = 1'b0;
      end else n = gaps_on ? $urandom_range(0, 4) : 0;
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // One input item; waits out a random gap, then holds it until accepted.
  task automatic send_word(input logic [63:0] w, input logic [3:0] vb, input logic lst);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, vb, w};
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Message of nw words; inner words get junk valid_bytes, which must be ignored.
  task automatic send_msg(input int nw, input logic [3:0] last_vb);
    for (int i = 0; i < nw - 1; i++) send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
    send_word(rand_word(), last_vb, 1'b1);
  endtask

  task automatic send_random_msg();
    case ($urandom_range(0, 7))
      0:       send_msg(16 * $urandom_range(1, 2), 4'd8);  // whole blocks
      1:       send_msg($urandom_range(17, 40), 4'($urandom_range(0, 15)));
      default: send_msg($urandom_range(1, 16), 4'($urandom_range(0, 15)));
    endcase
  endtask

  // Seed change only once the block is idle.
  task automatic set_seed(input logic [63:0] s);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= s;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset seed of zero.
    send_word('0, 4'd0, 1'b1);              // empty message
    send_word('1, 4'd8, 1'b1);              // one full word, all ones
    send_word('1, 4'd15, 1'b1);             // valid_bytes saturates
    send_word('1, 4'd3, 1'b1);              // upper bytes masked off
    send_msg(2, 4'd1);                      // short inner word ignored below
    send_word('1, 4'd2, 1'b0);
    send_word('1, 4'd0, 1'b1);              // last word carrying no bytes
    send_msg(16, 4'd8);                     // exactly one block: extra zero block
    send_msg(16, 4'd7);                     // one byte short of a block

    set_seed('1);
    send_msg(1, 4'd8);
    send_msg(17, 4'd4);                     // spills into a second block
    set_seed(64'h8000_0000_0000_0001);
    send_msg(3, 4'd5);

    // Random phases across seed settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_seed('0);
        1: set_seed({$urandom(), $urandom()});
        2: set_seed('1);
        default: set_seed({$urandom(), $urandom()});
      endcase
      gaps_on = (ph != 2);
      if (ph == 1) hold_req = 1'b1;
      while (sent < 25 + 135 * (ph + 1)) send_random_msg();
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
